// ===== rtl/gm3_pkg.sv =====
package gm3_pkg;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLUMNS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KX_COEFFS     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KY_COEFFS     = 8'd3;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam int GRAD_W = 19;
  localparam int MAG_W  = 27;
  localparam int SQ_W   = 38;
  localparam int RAD_W  = 54;
  localparam int REM_W  = 29;
  localparam int QAW    = 2;

  typedef logic [7:0] pix_t;

  // One window's worth of taps with out-of-image taps already zeroed.
  typedef struct packed {
    logic [7:0][7:0] pix;
    logic [11:0]     row;
    logic [9:0]      col;
    logic            last;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic signed [7:0] tap_of(input logic [63:0] c, input logic [2:0] k);
    return c[k*8 +: 8];
  endfunction

endpackage

// ===== rtl/gm3_fifo.sv =====
module gm3_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gm3_pkg::job_t  wdata,
  input  logic           pop,
  output gm3_pkg::job_t  rdata,
  output gm3_pkg::q_stat_t stat
);
  import gm3_pkg::*;

  localparam int DEPTH = 1 << QAW;

  job_t           mem [DEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == (QAW+1)'(DEPTH));
  assign rdata      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/gm3_front.sv =====
module gm3_front #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic                               req_type,
  input  logic [7:0]                         pixel,
  input  logic [$clog2(MAX_ROWS+1)-1:0]      rows_eff,
  input  logic [$clog2(MAX_COLS+1)-1:0]      cols_eff,
  output logic                               q_push,
  output gm3_pkg::job_t                      q_job,
  input  logic                               q_full
);
  import gm3_pkg::*;

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW1 = $clog2(MAX_ROWS+1);

  typedef enum logic {F_IDLE, F_UPD} fstate_t;

  fstate_t        state_r;
  logic [RW1-1:0] in_row_r, er_r;
  logic [CW-1:0]  in_col_r, ec_r;
  pix_t           newpix_r;
  pix_t           win_r [3][3];
  pix_t           upper_mem [MAX_COLS];
  pix_t           middle_mem [MAX_COLS];
  pix_t           up_q, mid_q;

  logic        accept, beyond, started, last, commit, rd_en;
  logic [31:0] rowsx, colsx, inrx, incx, erx, ecx;
  logic [2:0]  rv, cv;
  pix_t        nw [3][3];

  assign rowsx = 32'(rows_eff);
  assign colsx = 32'(cols_eff);
  assign inrx  = 32'(in_row_r);
  assign incx  = 32'(in_col_r);
  assign erx   = 32'(er_r);
  assign ecx   = 32'(ec_r);

  assign full    = (state_r != F_IDLE);
  assign accept  = push && !full;
  assign beyond  = inrx >= rowsx;
  assign rd_en   = accept && !(req_type == REQ_FLUSH && !beyond);
  assign started = (inrx >= 32'd2) || (inrx == 32'd1 && incx >= 32'd1);
  assign last    = (ecx + 32'd1 >= colsx) && (erx + 32'd1 >= rowsx);
  assign commit  = (state_r == F_UPD) && (!started || !q_full);
  assign q_push  = commit && started;

  // Which neighbour rows and columns of the emitted position lie in the image.
  assign rv[0] = (erx >= 32'd1) && (erx <= rowsx);
  assign rv[1] = erx < rowsx;
  assign rv[2] = erx + 32'd1 < rowsx;
  assign cv[0] = (ecx >= 32'd1) && (ecx <= colsx);
  assign cv[1] = ecx < colsx;
  assign cv[2] = ecx + 32'd1 < colsx;

  always_comb begin
    int k;
    k = 0;
    for (int r = 0; r < 3; r++) begin
      nw[r][0] = win_r[r][1];
      nw[r][1] = win_r[r][2];
    end
    nw[0][2] = up_q;
    nw[1][2] = mid_q;
    nw[2][2] = newpix_r;
    q_job.pix = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!(r == 1 && c == 1)) begin
          q_job.pix[k] = (rv[r] && cv[c]) ? nw[r][c] : 8'd0;
          k = k + 1;
        end
      end
    end
    q_job.row  = 12'(er_r);
    q_job.col  = 10'(ec_r);
    q_job.last = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      in_row_r <= '0;
      in_col_r <= '0;
      er_r     <= '0;
      ec_r     <= '0;
      newpix_r <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      case (state_r)
        F_IDLE: begin
          if (rd_en) begin
            newpix_r <= beyond ? 8'd0 : pixel;
            state_r  <= F_UPD;
          end
        end
        F_UPD: begin
          if (commit) begin
            win_r   <= nw;
            state_r <= F_IDLE;
            if (started && last) begin
              in_row_r <= '0;
              in_col_r <= '0;
              er_r     <= '0;
              ec_r     <= '0;
            end else begin
              if (incx + 32'd1 >= colsx) begin
                in_col_r <= '0;
                if (inrx < MAX_ROWS) begin
                  in_row_r <= in_row_r + 1'b1;
                end
              end else begin
                in_col_r <= CW'(incx + 32'd1);
              end
              if (started) begin
                if (ecx + 32'd1 >= colsx) begin
                  ec_r <= '0;
                  er_r <= er_r + 1'b1;
                end else begin
                  ec_r <= CW'(ecx + 32'd1);
                end
              end
            end
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  // Row stores: the upper row takes the old middle entry, the middle row the new pixel.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_q  <= upper_mem[in_col_r];
      mid_q <= middle_mem[in_col_r];
    end
    if (commit) begin
      upper_mem[in_col_r]  <= mid_q;
      middle_mem[in_col_r] <= newpix_r;
    end
  end

endmodule

// ===== rtl/gm3_back.sv =====
module gm3_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [63:0]                         kx_coeffs,
  input  logic [63:0]                         ky_coeffs,
  input  gm3_pkg::job_t                       q_job,
  input  gm3_pkg::q_stat_t                    q_stat,
  output logic                                q_pop,
  output logic                                res_write,
  input  logic                                res_ready,
  output logic signed [gm3_pkg::GRAD_W-1:0]   res_grad_x,
  output logic signed [gm3_pkg::GRAD_W-1:0]   res_grad_y,
  output logic [gm3_pkg::MAG_W-1:0]           res_magnitude,
  output logic [11:0]                         res_row,
  output logic [9:0]                          res_col,
  output logic                                res_last
);
  import gm3_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_MAC, B_SQ, B_SUM, B_ROOT, B_OUT} bstate_t;

  bstate_t                  state_r;
  job_t                     job_r;
  logic [2:0]               k_r;
  logic [4:0]               cnt_r;
  logic signed [GRAD_W-1:0] gx_r, gy_r;
  logic signed [SQ_W-1:0]   sqx_r, sqy_r;
  logic [RAD_W-1:0]         rad_r;
  logic [REM_W-1:0]         rem_r;
  logic [MAG_W-1:0]         root_r;

  logic signed [8:0]  pix_s;
  logic signed [16:0] px, py;
  logic [SQ_W-1:0]    sq_sum;
  logic [REM_W+1:0]   rem_n, trial;

  assign pix_s  = $signed({1'b0, job_r.pix[k_r]});
  assign px     = tap_of(kx_coeffs, k_r) * pix_s;
  assign py     = tap_of(ky_coeffs, k_r) * pix_s;
  assign sq_sum = $unsigned(sqx_r) + $unsigned(sqy_r);
  // One result bit per step of the digit-by-digit square root.
  assign rem_n  = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root_r, 2'b01});

  assign q_pop     = (state_r == B_IDLE) && !q_stat.empty;
  assign res_write = (state_r == B_OUT) && res_ready;

  assign res_grad_x    = gx_r;
  assign res_grad_y    = gy_r;
  assign res_magnitude = root_r;
  assign res_row       = job_r.row;
  assign res_col       = job_r.col;
  assign res_last      = job_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      k_r     <= '0;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            job_r   <= q_job;
            gx_r    <= '0;
            gy_r    <= '0;
            k_r     <= '0;
            state_r <= B_MAC;
          end
        end
        B_MAC: begin
          gx_r <= gx_r + {{2{px[16]}}, px};
          gy_r <= gy_r + {{2{py[16]}}, py};
          k_r  <= k_r + 1'b1;
          if (k_r == 3'd7) begin
            state_r <= B_SQ;
          end
        end
        B_SQ: begin
          sqx_r   <= gx_r * gx_r;
          sqy_r   <= gy_r * gy_r;
          state_r <= B_SUM;
        end
        B_SUM: begin
          rad_r   <= {sq_sum, 16'd0};
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= 5'(MAG_W - 1);
          state_r <= B_ROOT;
        end
        B_ROOT: begin
          if (rem_n >= trial) begin
            rem_r  <= REM_W'(rem_n - trial);
            root_r <= {root_r[MAG_W-2:0], 1'b1};
          end else begin
            rem_r  <= REM_W'(rem_n);
            root_r <= {root_r[MAG_W-2:0], 1'b0};
          end
          rad_r <= {rad_r[RAD_W-3:0], 2'b00};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (res_ready) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/gradient_magnitude_3x3_top.sv =====
// From the request that completes a position's neighbourhood, the work passes the front
// end and queue, a multiply-accumulate over the eight taps, squares and sum, 27
// square-root steps and the load into the output register. The front end accepts no new
// request until the last is committed, and that commit waits while the 4-entry queue is full;
// the back end's shared accumulator and bit-serial square root handle one position at a time.
// Reset is synchronous and active low; it clears control state and the window and
// restores the configuration registers. Line store contents are not cleared.
module gradient_magnitude_3x3_top #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic                                in_req_type,
  input  logic [7:0]                          in_pixel,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [gm3_pkg::GRAD_W-1:0]   out_grad_x,
  output logic signed [gm3_pkg::GRAD_W-1:0]   out_grad_y,
  output logic [gm3_pkg::MAG_W-1:0]           out_magnitude,
  output logic [11:0]                         out_row,
  output logic [9:0]                          out_col,
  output logic                                out_last_of_frame,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gm3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [63:0]                         cfg_data
);
  import gm3_pkg::*;

  localparam int CW1 = $clog2(MAX_COLS+1);
  localparam int RW1 = $clog2(MAX_ROWS+1);

  logic [12:0]    image_rows_r;
  logic [10:0]    image_columns_r;
  logic [63:0]    kx_r, ky_r;
  logic [RW1-1:0] rows_eff;
  logic [CW1-1:0] cols_eff;

  job_t    f_job, q_head;
  logic    f_push, q_pop;
  q_stat_t q_stat;

  logic                     res_write, res_ready, res_last;
  logic signed [GRAD_W-1:0] res_gx, res_gy;
  logic [MAG_W-1:0]         res_mag;
  logic [11:0]              res_row;
  logic [9:0]               res_col;
  logic                     out_valid_r;

  assign cfg_ready = 1'b1;

  assign rows_eff = (image_rows_r == '0) ? RW1'(1) :
                    (32'(image_rows_r) > MAX_ROWS) ? RW1'(MAX_ROWS) : RW1'(image_rows_r);
  assign cols_eff = (image_columns_r == '0) ? CW1'(1) :
                    (32'(image_columns_r) > MAX_COLS) ? CW1'(MAX_COLS) : CW1'(image_columns_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_rows_r    <= 13'd4096;
      image_columns_r <= 11'd1024;
      kx_r            <= '0;
      ky_r            <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_ROWS:    image_rows_r    <= cfg_data[12:0];
        REG_IMAGE_COLUMNS: image_columns_r <= cfg_data[10:0];
        REG_KX_COEFFS:     kx_r            <= cfg_data;
        REG_KY_COEFFS:     ky_r            <= cfg_data;
        default: ;
      endcase
    end
  end

  gm3_front #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .req_type (in_req_type),
    .pixel    (in_pixel),
    .rows_eff (rows_eff),
    .cols_eff (cols_eff),
    .q_push   (f_push),
    .q_job    (f_job),
    .q_full   (q_stat.full)
  );

  gm3_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_job),
    .pop   (q_pop),
    .rdata (q_head),
    .stat  (q_stat)
  );

  gm3_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .kx_coeffs     (kx_r),
    .ky_coeffs     (ky_r),
    .q_job         (q_head),
    .q_stat        (q_stat),
    .q_pop         (q_pop),
    .res_write     (res_write),
    .res_ready     (res_ready),
    .res_grad_x    (res_gx),
    .res_grad_y    (res_gy),
    .res_magnitude (res_mag),
    .res_row       (res_row),
    .res_col       (res_col),
    .res_last      (res_last)
  );

  // Output register: a new result may load in the same cycle the old one is popped.
  assign res_ready = !out_valid_r || pop;
  assign empty     = !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_write) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_write) begin
      out_grad_x        <= res_gx;
      out_grad_y        <= res_gy;
      out_magnitude     <= res_mag;
      out_row           <= res_row;
      out_col           <= res_col;
      out_last_of_frame <= res_last;
    end
  end

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    f_push |-> !q_stat.full)
    else $error("front end wrote into a full queue");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("back end read from an empty queue");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("waiting result was lost");

  a_zero_magnitude: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_magnitude == '0) == (out_grad_x == '0 && out_grad_y == '0)))
    else $error("magnitude disagrees with gradients");

endmodule
